/* hw/rtl/ptts_pkg.sv */
package ptts_pkg;

    // Bank size and counter width
    localparam int NUM_TASKS   = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int PERIOD_W    = 16;
    localparam int FIRE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int INDEX_W     = 8;
    localparam int TASK_SEL_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CMP_W       = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Request kinds
    localparam logic [KIND_W-1:0] REQ_TICK        = 3'd0;
    localparam logic [KIND_W-1:0] REQ_ENABLE      = 3'd1;
    localparam logic [KIND_W-1:0] REQ_DISABLE     = 3'd2;
    localparam logic [KIND_W-1:0] REQ_SET_PERIOD  = 3'd3;
    localparam logic [KIND_W-1:0] REQ_READ_STATUS = 3'd4;

    // Status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]   req_type;
        logic [INDEX_W-1:0]  task_index;
        logic [PERIOD_W-1:0] period_value;
    } req_t;

    typedef struct packed {
        logic [FIRE_W-1:0] fire_mask;
        logic              status_code;
        logic              task_enabled;
    } rsp_t;

    // Command from the input stage to the task bank
    typedef struct packed {
        logic                  go;
        logic [KIND_W-1:0]     kind;
        logic                  in_range;
        logic [TASK_SEL_W-1:0] sel;
        logic [PERIOD_W-1:0]   period;
    } bank_cmd_t;

    typedef struct packed {
        logic [FIRE_W-1:0] fire_mask;
        logic              task_enabled;
    } bank_res_t;

    // Period of each task after reset
    function automatic logic [PERIOD_W-1:0] reset_period(input int idx);
        logic [PERIOD_W-1:0] p;
        unique case (idx)
            0:       p = 16'd1000;
            1:       p = 16'd40;
            2:       p = 16'd80;
            3:       p = 16'd60;
            4:       p = 16'd1000;
            5:       p = 16'd5000;
            6:       p = 16'd3000;
            7:       p = 16'd100;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/ptts_task_bank.sv */
module ptts_task_bank
    import ptts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bank_cmd_t cmd,
    output bank_res_t res
);

    logic [PERIOD_W-1:0]    period_reg [NUM_TASKS];
    logic [PERIOD_W-1:0]    period_next [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] count_reg [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_TASKS];
    logic [NUM_TASKS-1:0]   enable_reg;
    logic [NUM_TASKS-1:0]   enable_next;
    logic [NUM_TASKS-1:0]   hit;

    // Per-task counter update: saturating increment, one compare
    for (genvar t = 0; t < NUM_TASKS; t++)
    begin : g_task
        logic [COUNT_WIDTH-1:0] inc;
        logic                   addressed;

        assign inc = (count_reg[t] == COUNT_MAX) ? count_reg[t]
                                                 : count_reg[t] + 1'b1;
        assign hit[t] = enable_reg[t]
                      && (CMP_W'(inc) >= CMP_W'(period_reg[t]));
        assign addressed = cmd.in_range
                         && (cmd.sel == TASK_SEL_W'(t));

        always_comb
        begin
            period_next[t] = period_reg[t];
            count_next[t]  = count_reg[t];
            enable_next[t] = enable_reg[t];
            if (cmd.go)
            begin
                if (cmd.kind == REQ_TICK)
                begin
                    if (enable_reg[t])
                        count_next[t] = hit[t] ? '0 : inc;
                end
                else if (addressed)
                begin
                    if (cmd.kind == REQ_ENABLE)
                        enable_next[t] = 1'b1;
                    else if (cmd.kind == REQ_DISABLE)
                    begin
                        enable_next[t] = 1'b0;
                        count_next[t]  = '0;
                    end
                    else if (cmd.kind == REQ_SET_PERIOD)
                        period_next[t] = cmd.period;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                period_reg[t] <= reset_period(t);
                count_reg[t]  <= '0;
                enable_reg[t] <= 1'b0;
            end
            else
            begin
                period_reg[t] <= period_next[t];
                count_reg[t]  <= count_next[t];
                enable_reg[t] <= enable_next[t];
            end
        end
    end

    // Fire mask shows tasks 0..FIRE_W-1 only
    for (genvar b = 0; b < FIRE_W; b++)
    begin : g_fire
        if (b < NUM_TASKS)
        begin : g_live
            assign res.fire_mask[b] = (cmd.kind == REQ_TICK) && hit[b];
        end
        else
        begin : g_pad
            assign res.fire_mask[b] = 1'b0;
        end
    end

    // Status read of the addressed task
    assign res.task_enabled = (cmd.kind == REQ_READ_STATUS) && cmd.in_range
                            && enable_reg[cmd.sel];

endmodule

/* hw/rtl/periodic_task_tick_scheduler_core.sv */
// A request transaction passes the input register, then the response register.
// Throughput: one request per cycle unless the receiver stalls; the input and
// response registers each hold one transaction; task counters update in parallel.
// Reset (rst_n low, asynchronous): all tasks disabled, counters cleared,
// periods back to their defaults, both stages empty.
module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic      in_vld_reg;
    req_t      in_reg;
    logic      rsp_vld_reg;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;
    logic      advance;
    logic      in_range;
    bank_cmd_t cmd;
    bank_res_t res;

    // Stage moves on when the response register is free or being emptied
    assign advance   = !rsp_vld_reg || !rsp_stall;
    assign req_stall = in_vld_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!req_stall)
            in_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_reg <= req;
    end

    // Decode for the task bank
    assign in_range = in_reg.task_index < INDEX_W'(NUM_TASKS);

    always_comb
    begin
        cmd.go       = in_vld_reg && advance;
        cmd.kind     = in_reg.req_type;
        cmd.in_range = in_range;
        cmd.sel      = in_reg.task_index[TASK_SEL_W-1:0];
        cmd.period   = in_reg.period_value;
    end

    ptts_task_bank u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    // Response assembly
    always_comb
    begin
        rsp_next.fire_mask    = res.fire_mask;
        rsp_next.task_enabled = res.task_enabled;
        if ((in_reg.req_type != REQ_TICK) && (in_reg.req_type <= REQ_READ_STATUS)
            && !in_range)
            rsp_next.status_code = STATUS_BAD_INDEX;
        else
            rsp_next.status_code = STATUS_OK;
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (advance)
            rsp_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (in_vld_reg && rsp_vld_reg))
        else $error("input stalled with a free stage");

    a_move_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |=> rsp_vld_reg)
        else $error("transaction lost between stages");

    a_bad_index_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && (rsp_reg.status_code == STATUS_BAD_INDEX))
        |-> ((rsp_reg.fire_mask == '0) && !rsp_reg.task_enabled))
        else $error("bad index response carries data");

    a_status_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_reg.task_enabled) |-> (rsp_reg.fire_mask == '0))
        else $error("status read reports firing");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import ptts_pkg::*;

    // Run shape
    localparam int RESET_CYCLES    = 11;
    localparam int DIRECTED_N      = 25;
    localparam int RANDOM_N        = 1325;
    localparam int QUIET_TAIL      = 150;
    localparam int HOLD_OFF_AT     = DIRECTED_N + 300;
    localparam int HOLD_OFF_CYCLES = 48;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;

    // Request kinds the block does not define
    localparam logic [KIND_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [KIND_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] REQ_RSVD7 = 3'd7;

    // Periods loaded at reset for the first eight tasks
    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD [0:7] = '{
        16'd1000, 16'd40, 16'd80, 16'd60, 16'd1000, 16'd5000, 16'd3000, 16'd100
    };

    localparam rsp_t RSP_QUIET     = '{8'h00, STATUS_OK, 1'b0};
    localparam rsp_t RSP_BAD_INDEX = '{8'h00, STATUS_BAD_INDEX, 1'b0};

    // One row of the directed sequence; 'typed' marks a hand-written response
    typedef struct packed {
        req_t stim;
        logic typed;
        rsp_t want;
    } row_t;

    localparam row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
        // state straight after reset
        '{'{REQ_READ_STATUS, 8'd0,   16'h0000}, 1'b1, RSP_QUIET},
        '{'{REQ_ENABLE,      8'd0,   16'h0000}, 1'b1, RSP_QUIET},
        '{'{REQ_READ_STATUS, 8'd0,   16'h0000}, 1'b1, '{8'h00, STATUS_OK, 1'b1}},
        // zero period fires on every tick
        '{'{REQ_SET_PERIOD,  8'd0,   16'h0000}, 1'b1, RSP_QUIET},
        '{'{REQ_TICK,        8'd0,   16'h0000}, 1'b1, '{8'h01, STATUS_OK, 1'b0}},
        '{'{REQ_ENABLE,      8'd7,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_SET_PERIOD,  8'd7,   16'hFFFF}, 1'b0, RSP_QUIET},
        '{'{REQ_ENABLE,      8'd1,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_TICK,        8'd0,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_TICK,        8'd0,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_TICK,        8'd0,   16'h0000}, 1'b0, RSP_QUIET},
        // period dropped below the running count: fires on the next tick
        '{'{REQ_SET_PERIOD,  8'd1,   16'h0002}, 1'b0, RSP_QUIET},
        '{'{REQ_TICK,        8'd0,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_DISABLE,     8'd0,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_TICK,        8'd0,   16'h0000}, 1'b0, RSP_QUIET},
        // index outside the bank
        '{'{REQ_READ_STATUS, 8'd255, 16'h0000}, 1'b1, RSP_BAD_INDEX},
        '{'{REQ_ENABLE,      8'd8,   16'h0000}, 1'b1, RSP_BAD_INDEX},
        '{'{REQ_DISABLE,     8'hAA,  16'h0000}, 1'b1, RSP_BAD_INDEX},
        '{'{REQ_SET_PERIOD,  8'h55,  16'h5555}, 1'b1, RSP_BAD_INDEX},
        // unknown kinds leave everything alone
        '{'{REQ_RSVD5,       8'd0,   16'h0000}, 1'b1, RSP_QUIET},
        '{'{REQ_RSVD6,       8'h7F,  16'hAAAA}, 1'b1, RSP_QUIET},
        '{'{REQ_RSVD7,       8'hFF,  16'hFFFF}, 1'b1, RSP_QUIET},
        // tick ignores its index and period fields
        '{'{REQ_TICK,        8'hFF,  16'hFFFF}, 1'b0, RSP_QUIET},
        '{'{REQ_READ_STATUS, 8'd7,   16'h0000}, 1'b0, RSP_QUIET},
        '{'{REQ_DISABLE,     8'd7,   16'h0000}, 1'b0, RSP_QUIET}
    };

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Scheduler state as the checker sees it
    logic [PERIOD_W-1:0]    task_period [NUM_TASKS];
    logic                   task_on     [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] tick_count  [NUM_TASKS];

    rsp_t expected_rsp [$];
    int   n_accepted    = 0;
    int   n_checked     = 0;
    int   fail_count    = 0;
    int   idle_pct      = 0;
    int   stall_pct     = 0;
    int   cycle_count   = 0;
    logic hold_off_done = 1'b0;
    logic quiet;

    assign quiet = (n_accepted >= DIRECTED_N + RANDOM_N - QUIET_TAIL);

    periodic_task_tick_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Run-away guard
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // Advance the scheduler by one request and return its response
    function automatic rsp_t schedule_step(input req_t r);
        rsp_t o;
        int   t;
        o = RSP_QUIET;
        t = int'(r.task_index);
        if (r.req_type == REQ_TICK)
        begin
            for (int k = 0; k < NUM_TASKS; k++)
            begin
                if (task_on[k])
                begin
                    if (tick_count[k] != COUNT_MAX)
                        tick_count[k] = tick_count[k] + 1'b1;
                    if (tick_count[k] >= task_period[k])
                    begin
                        tick_count[k] = '0;
                        if (k < FIRE_W)
                            o.fire_mask[k] = 1'b1;
                    end
                end
            end
        end
        else if (r.req_type <= REQ_READ_STATUS)
        begin
            if (t >= NUM_TASKS)
                o.status_code = STATUS_BAD_INDEX;
            else
            begin
                case (r.req_type)
                    REQ_ENABLE:
                        task_on[t] = 1'b1;
                    REQ_DISABLE:
                    begin
                        task_on[t]    = 1'b0;
                        tick_count[t] = '0;
                    end
                    REQ_SET_PERIOD:
                        task_period[t] = r.period_value;
                    default:
                        o.task_enabled = task_on[t];
                endcase
            end
        end
        return o;
    endfunction

    // Offer one request transaction, possibly after a short gap
    task automatic send_request(input req_t r, input logic typed, input rsp_t want);
        rsp_t predicted;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        predicted = schedule_step(r);
        expected_rsp.push_back(typed ? want : predicted);
        n_accepted++;
    endtask

    // Receiver: random stall bursts, one long hold-off to back the block up
    initial
    begin
        int span;
        span = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            span++;
            if (span % 64 == 0)
                stall_pct = int'(10 * $urandom_range(0, 3));
            if (!hold_off_done && n_accepted >= HOLD_OFF_AT)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rsp_stall     <= 1'b0;
                hold_off_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected response transaction: fire %h status %b enabled %b",
                             rsp.fire_mask, rsp.status_code, rsp.task_enabled);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.fire_mask !== want.fire_mask || rsp.status_code !== want.status_code
                    || rsp.task_enabled !== want.task_enabled)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"response %0d: expected fire %h status %b enabled %b,",
                                  " got fire %h status %b enabled %b"},
                                 n_checked, want.fire_mask, want.status_code, want.task_enabled,
                                 rsp.fire_mask, rsp.status_code, rsp.task_enabled);
                end
            end
            n_checked++;
        end
    end

    // Stimulus
    initial
    begin
        req_t r;
        int   pick;
        for (int k = 0; k < NUM_TASKS; k++)
        begin
            task_period[k] = (k < 8) ? DEFAULT_PERIOD[k] : '0;
            task_on[k]     = 1'b0;
            tick_count[k]  = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_request(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // Half ticks, against small periods so tasks fire often
        for (int i = 0; i < RANDOM_N; i++)
        begin
            if (i % 64 == 0)
                idle_pct = int'(15 * $urandom_range(0, 2));
            r.task_index   = INDEX_W'($urandom_range(0, NUM_TASKS - 1));
            r.period_value = PERIOD_W'($urandom);
            pick           = int'($urandom_range(0, 99));
            if (pick < 50)
            begin
                r.req_type   = REQ_TICK;
                r.task_index = INDEX_W'($urandom);
            end
            else if (pick < 62)
                r.req_type = REQ_ENABLE;
            else if (pick < 68)
                r.req_type = REQ_DISABLE;
            else if (pick < 80)
            begin
                r.req_type = REQ_SET_PERIOD;
                if ($urandom_range(0, 9) != 0)
                    r.period_value = PERIOD_W'($urandom_range(0, 12));
            end
            else if (pick < 90)
                r.req_type = REQ_READ_STATUS;
            else if (pick < 96)
            begin
                r.task_index = INDEX_W'($urandom_range(NUM_TASKS, 255));
                case ($urandom_range(0, 3))
                    0:       r.req_type = REQ_ENABLE;
                    1:       r.req_type = REQ_DISABLE;
                    2:       r.req_type = REQ_SET_PERIOD;
                    default: r.req_type = REQ_READ_STATUS;
                endcase
            end
            else
            begin
                r.task_index = INDEX_W'($urandom);
                case ($urandom_range(0, 2))
                    0:       r.req_type = REQ_RSVD5;
                    1:       r.req_type = REQ_RSVD6;
                    default: r.req_type = REQ_RSVD7;
                endcase
            end
            send_request(r, 1'b0, RSP_QUIET);
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
